// ===== src/uvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package uvs_pkg;

	// defaults for the top level parameters
	localparam int MAX_DIVISIONS_DEF = 1024;
	localparam int FRAC_BITS_DEF     = 15;

	// field widths
	localparam int CNT_W     = 11;
	localparam int IDX_W     = 10;
	localparam int OUT_W     = 16;
	localparam int SLOT_W    = 3;
	localparam int REG_IDX_W = 2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_LONGITUDE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LATITUDE  = 2'd1;

	localparam int LON_RESET = 32;
	localparam int LAT_RESET = 16;

	localparam logic [SLOT_W-1:0] LAST_SLOT = 3'd5;

	localparam int QUEUE_DEPTH = 2;

	// quotient of a * 2^33 / d with a <= d
	localparam int DIV_QBITS = 34;
	localparam int PHASE_W   = 32;

	// rotation unit, Q4.30 datapath
	localparam int CORDIC_STEPS = 30;
	localparam int CW           = 34;
	localparam int FIX_FRAC     = 30;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	typedef struct packed {
		logic [CNT_W-1:0] lon;
		logic [CNT_W-1:0] lat;
	} grid_cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] column;
		logic [IDX_W-1:0] row;
		logic             err;
	} cell_req_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              last;
		logic              err;
	} vtx_meta_t;

	// arctangent of 2^-i in phase units (2^32 = one turn)
	function automatic logic signed [CW-1:0] atan_step(input int i);
		logic signed [CW-1:0] a;
		unique case (i)
			0:  a = 34'sd536870912;
			1:  a = 34'sd316933406;
			2:  a = 34'sd167458907;
			3:  a = 34'sd85004756;
			4:  a = 34'sd42667331;
			5:  a = 34'sd21354465;
			6:  a = 34'sd10679838;
			7:  a = 34'sd5340245;
			8:  a = 34'sd2670163;
			9:  a = 34'sd1335087;
			10: a = 34'sd667544;
			11: a = 34'sd333772;
			12: a = 34'sd166886;
			13: a = 34'sd83443;
			14: a = 34'sd41722;
			15: a = 34'sd20861;
			16: a = 34'sd10430;
			17: a = 34'sd5215;
			18: a = 34'sd2608;
			19: a = 34'sd1304;
			20: a = 34'sd652;
			21: a = 34'sd326;
			22: a = 34'sd163;
			23: a = 34'sd81;
			24: a = 34'sd41;
			25: a = 34'sd20;
			26: a = 34'sd10;
			27: a = 34'sd5;
			28: a = 34'sd3;
			29: a = 34'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

	// next column used by this vertex
	function automatic logic slot_du(input logic [SLOT_W-1:0] s);
		logic r;
		unique case (s) inside
			3'd2, 3'd4, 3'd5: r = 1'b1;
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

	// next row used by this vertex
	function automatic logic slot_dv(input logic [SLOT_W-1:0] s);
		logic r;
		unique case (s) inside
			3'd1, 3'd2, 3'd4: r = 1'b1;
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/uvs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uvs_front #(
	parameter int MAX_DIVISIONS = uvs_pkg::MAX_DIVISIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [uvs_pkg::IDX_W-1:0]      column,
	input  logic [uvs_pkg::IDX_W-1:0]      row,
	output logic                           busy,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [uvs_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [uvs_pkg::CNT_W-1:0]      cfg_data,
	output uvs_pkg::grid_cfg_t             grid,
	input  uvs_pkg::queue_status_t         q_status,
	output logic                           push,
	output uvs_pkg::cell_req_t             req
);
	import uvs_pkg::*;

	localparam logic [CNT_W-1:0] LON_RST =
		(LON_RESET > MAX_DIVISIONS) ? CNT_W'(MAX_DIVISIONS) : CNT_W'(LON_RESET);
	localparam logic [CNT_W-1:0] LAT_RST =
		(LAT_RESET > MAX_DIVISIONS) ? CNT_W'(MAX_DIVISIONS) : CNT_W'(LAT_RESET);

	function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
		return (int'(v) > MAX_DIVISIONS) ? CNT_W'(MAX_DIVISIONS) : v;
	endfunction

	logic [CNT_W-1:0] lon_q, lat_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lon_q <= LON_RST;
			lat_q <= LAT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LONGITUDE: lon_q <= sat_count(cfg_data);
				REG_LATITUDE:  lat_q <= sat_count(cfg_data);
				default: ;
			endcase
		end
	end

	assign grid.lon = lon_q;
	assign grid.lat = lat_q;

	// classify: outside the grid still yields six (zeroed) vertices
	assign busy       = q_status.full;
	assign push       = start && !busy;
	assign req.column = column;
	assign req.row    = row;
	assign req.err    = !((CNT_W'(column) < lon_q) && (CNT_W'(row) < lat_q));

endmodule

`default_nettype wire

// ===== src/uvs_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uvs_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  uvs_pkg::cell_req_t     wdata,
	input  logic                   pop,
	output uvs_pkg::cell_req_t     rdata,
	output uvs_pkg::queue_status_t status
);
	import uvs_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cell_req_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push, do_pop;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rdata        = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

`default_nettype wire

// ===== src/uvs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// floor(num * 2^(DIV_QBITS-1) / den), one quotient bit per stage
module uvs_div (
	input  logic                            clk,
	input  logic [uvs_pkg::CNT_W-1:0]       num,
	input  logic [uvs_pkg::CNT_W-1:0]       den,
	output logic [uvs_pkg::DIV_QBITS-1:0]   quo
);
	import uvs_pkg::*;

	localparam int QB = DIV_QBITS;

	logic [CNT_W-1:0] rem_q [QB];
	logic [CNT_W-1:0] den_q [QB];
	logic [QB-1:0]    quo_q [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [CNT_W:0]   t;
		logic [CNT_W-1:0] dk;
		logic [QB-1:0]    qk;
		logic             take;

		if (k == 0) begin : g_first
			assign t  = {1'b0, num};
			assign dk = den;
			assign qk = '0;
		end else begin : g_next
			assign t  = {rem_q[k-1], 1'b0};
			assign dk = den_q[k-1];
			assign qk = quo_q[k-1];
		end

		assign take = (t >= {1'b0, dk});

		always_ff @(posedge clk) begin
			rem_q[k] <= take ? CNT_W'(t - {1'b0, dk}) : CNT_W'(t);
			den_q[k] <= dk;
			quo_q[k] <= {qk[QB-2:0], take};
		end
	end

	assign quo = quo_q[QB-1];

endmodule

`default_nettype wire

// ===== src/uvs_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none

// rotation mode, one micro-rotation per stage, quadrant fold at the end
module uvs_cordic (
	input  logic                              clk,
	input  logic [uvs_pkg::PHASE_W-1:0]       phase,
	output logic signed [uvs_pkg::CW-1:0]     cos_val,
	output logic signed [uvs_pkg::CW-1:0]     sin_val
);
	import uvs_pkg::*;

	localparam int NS = CORDIC_STEPS;

	logic signed [CW-1:0] x_q [NS];
	logic signed [CW-1:0] y_q [NS];
	logic signed [CW-1:0] z_q [NS];
	logic [1:0]           quad_q [NS];

	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic signed [CW-1:0] xi, yi, zi;
		logic [1:0]           qi;

		if (i == 0) begin : g_first
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = CW'(phase[PHASE_W-3:0]);
			assign qi = phase[PHASE_W-1 -: 2];
		end else begin : g_next
			assign xi = x_q[i-1];
			assign yi = y_q[i-1];
			assign zi = z_q[i-1];
			assign qi = quad_q[i-1];
		end

		always_ff @(posedge clk) begin
			if (!zi[CW-1]) begin
				x_q[i] <= xi - (yi >>> i);
				y_q[i] <= yi + (xi >>> i);
				z_q[i] <= zi - atan_step(i);
			end else begin
				x_q[i] <= xi + (yi >>> i);
				y_q[i] <= yi - (xi >>> i);
				z_q[i] <= zi + atan_step(i);
			end
			quad_q[i] <= qi;
		end
	end

	always_ff @(posedge clk) begin
		unique case (quad_q[NS-1])
			QUAD_0: begin
				cos_val <= x_q[NS-1];
				sin_val <= y_q[NS-1];
			end
			QUAD_1: begin
				cos_val <= -y_q[NS-1];
				sin_val <= x_q[NS-1];
			end
			QUAD_2: begin
				cos_val <= -x_q[NS-1];
				sin_val <= -y_q[NS-1];
			end
			default: begin
				cos_val <= y_q[NS-1];
				sin_val <= -x_q[NS-1];
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/uvs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uvs_back #(
	parameter int FRAC_BITS = uvs_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  uvs_pkg::grid_cfg_t                 grid,
	input  uvs_pkg::cell_req_t                 head,
	input  uvs_pkg::queue_status_t             q_status,
	output logic                               pop,
	output logic                               vertex_valid,
	output logic signed [uvs_pkg::OUT_W-1:0]   pos_x,
	output logic signed [uvs_pkg::OUT_W-1:0]   pos_y,
	output logic signed [uvs_pkg::OUT_W-1:0]   pos_z,
	output logic [uvs_pkg::OUT_W-1:0]          tex_s,
	output logic [uvs_pkg::OUT_W-1:0]          tex_t,
	output logic [uvs_pkg::SLOT_W-1:0]         vertex_slot,
	output logic                               last,
	output logic                               cell_error
);
	import uvs_pkg::*;

	localparam int META_LAT = DIV_QBITS + CORDIC_STEPS + 4;
	localparam int TEX_LAT  = CORDIC_STEPS + 3;
	localparam int TEX_SH   = DIV_QBITS - 2 - FRAC_BITS;
	localparam int POS_SH   = FIX_FRAC - FRAC_BITS;
	localparam int PW       = 2 * CW;

	localparam logic signed [PW-1:0] PROD_RND = PW'(1) << (FIX_FRAC - 1);
	localparam logic signed [CW-1:0] POS_RND  = CW'((64'(1) << POS_SH) >> 1);
	localparam logic signed [CW-1:0] POS_ONE  = CW'(64'(1) << FRAC_BITS);
	localparam logic signed [CW-1:0] POS_MAX  = CW'(32767);
	localparam logic signed [CW-1:0] POS_MIN  = -CW'(32768);
	localparam logic [DIV_QBITS-1:0] TEX_MAX  = DIV_QBITS'(16'hFFFF);

	function automatic logic [OUT_W-1:0] pos_out(input logic signed [CW-1:0] q);
		logic signed [CW-1:0] r;
		r = (q + POS_RND) >>> POS_SH;
		if (r > POS_ONE) r = POS_ONE;
		else if (r < -POS_ONE) r = -POS_ONE;
		if (r > POS_MAX) r = POS_MAX;
		else if (r < POS_MIN) r = POS_MIN;
		return r[OUT_W-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] tex_round(input logic [DIV_QBITS-1:0] q);
		logic [DIV_QBITS-1:0] t;
		t = ((q >> TEX_SH) + DIV_QBITS'(1)) >> 1;
		return (t > TEX_MAX) ? '1 : t[OUT_W-1:0];
	endfunction

	// ---- vertex sequencer: six slots per request ----
	logic              active_q;
	logic [SLOT_W-1:0] slot_q;
	cell_req_t         cur_q;

	assign pop = !q_status.empty && (!active_q || slot_q == LAST_SLOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			slot_q   <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			slot_q   <= '0;
		end else if (active_q && slot_q == LAST_SLOT) begin
			active_q <= 1'b0;
		end else if (active_q) begin
			slot_q <= slot_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
	end

	// ---- s1: vertex column / row ----
	logic [CNT_W-1:0] u_inc, cu, rv;
	logic             valid_s1;
	logic [CNT_W-1:0] cu_s1, rv_s1, tr_s1;
	vtx_meta_t        meta_s1;

	assign u_inc = CNT_W'(cur_q.column) + CNT_W'(1);
	assign cu    = slot_du(slot_q) ? ((u_inc < grid.lon) ? u_inc : '0)
	                               : CNT_W'(cur_q.column);
	assign rv    = CNT_W'(cur_q.row) + CNT_W'(slot_dv(slot_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= active_q;
	end

	always_ff @(posedge clk) begin
		cu_s1        <= cu;
		rv_s1        <= rv;
		tr_s1        <= grid.lat - rv;
		meta_s1.slot <= slot_q;
		meta_s1.last <= (slot_q == LAST_SLOT);
		meta_s1.err  <= cur_q.err;
	end

	// ---- dividers ----
	logic [DIV_QBITS-1:0] q_th, q_ph, q_tt;

	uvs_div u_div_th (.clk(clk), .num(cu_s1), .den(grid.lon), .quo(q_th));
	uvs_div u_div_ph (.clk(clk), .num(rv_s1), .den(grid.lat), .quo(q_ph));
	uvs_div u_div_tt (.clk(clk), .num(tr_s1), .den(grid.lat), .quo(q_tt));

	// ---- s2: phases and texture ----
	logic [DIV_QBITS-1:0] th_sum, ph_sum;
	logic [PHASE_W-1:0]   theta_s2, phi_s2;
	logic [OUT_W-1:0]     tex_s_s2, tex_t_s2;

	assign th_sum = q_th + DIV_QBITS'(1);
	assign ph_sum = (q_ph >> 1) + DIV_QBITS'(1);

	always_ff @(posedge clk) begin
		theta_s2 <= th_sum[PHASE_W:1];
		phi_s2   <= ph_sum[PHASE_W:1];
		tex_s_s2 <= tex_round(q_th);
		tex_t_s2 <= tex_round(q_tt);
	end

	// ---- sine / cosine ----
	logic signed [CW-1:0] ct, st, cp, sp;

	uvs_cordic u_cordic_th (.clk(clk), .phase(theta_s2), .cos_val(ct), .sin_val(st));
	uvs_cordic u_cordic_ph (.clk(clk), .phase(phi_s2), .cos_val(cp), .sin_val(sp));

	// ---- s3: products, s4: back to Q4.30 ----
	logic signed [PW-1:0] prod_x_s3, prod_y_s3;
	logic signed [CW-1:0] cp_s3, qx_s4, qy_s4, qz_s4;

	always_ff @(posedge clk) begin
		prod_x_s3 <= sp * ct;
		prod_y_s3 <= sp * st;
		cp_s3     <= cp;
		qx_s4     <= CW'((prod_x_s3 + PROD_RND) >>> FIX_FRAC);
		qy_s4     <= CW'((prod_y_s3 + PROD_RND) >>> FIX_FRAC);
		qz_s4     <= cp_s3;
	end

	// ---- side band delay lines ----
	logic             valid_dly_q [META_LAT];
	vtx_meta_t        meta_dly_q  [META_LAT];
	logic [OUT_W-1:0] tex_s_dly_q [TEX_LAT];
	logic [OUT_W-1:0] tex_t_dly_q [TEX_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < META_LAT; k++) valid_dly_q[k] <= 1'b0;
		end else begin
			valid_dly_q[0] <= valid_s1;
			for (int k = 1; k < META_LAT; k++) valid_dly_q[k] <= valid_dly_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		meta_dly_q[0]  <= meta_s1;
		tex_s_dly_q[0] <= tex_s_s2;
		tex_t_dly_q[0] <= tex_t_s2;
		for (int k = 1; k < META_LAT; k++) meta_dly_q[k] <= meta_dly_q[k-1];
		for (int k = 1; k < TEX_LAT; k++) begin
			tex_s_dly_q[k] <= tex_s_dly_q[k-1];
			tex_t_dly_q[k] <= tex_t_dly_q[k-1];
		end
	end

	// ---- output register ----
	vtx_meta_t meta_o;
	assign meta_o = meta_dly_q[META_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vertex_valid <= 1'b0;
		else         vertex_valid <= valid_dly_q[META_LAT-1];
	end

	always_ff @(posedge clk) begin
		vertex_slot <= meta_o.slot;
		last        <= meta_o.last;
		cell_error  <= meta_o.err;
		if (meta_o.err) begin
			pos_x <= '0;
			pos_y <= '0;
			pos_z <= '0;
			tex_s <= '0;
			tex_t <= '0;
		end else begin
			pos_x <= pos_out(qx_s4);
			pos_y <= pos_out(qy_s4);
			pos_z <= pos_out(qz_s4);
			tex_s <= tex_s_dly_q[TEX_LAT-1];
			tex_t <= tex_t_dly_q[TEX_LAT-1];
		end
	end

endmodule

`default_nettype wire

// ===== src/uv_sphere_cell_tessellator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Payload
// -------   ---------------------     -----------------------------------------------
// cell in   start / busy              column, row
// vertex    vertex_valid (strobe)     pos_x, pos_y, pos_z, tex_s, tex_t, vertex_slot,
//                                     last, cell_error
// config    cfg_valid / cfg_ready     cfg_index (0 longitude, 1 latitude), cfg_data
//
// A request is taken when start is high and busy low; each cell yields six vertices,
// one per cycle, so the sustained cell rate is set by the vertex sequencer feeding
// the single result port. After a request is taken, its first vertex passes the
// request queue, the sequencer, 34 divider stages, the rotation stages and the
// product / rounding registers.
// busy rises only when the two-entry request queue is full; the result side has no
// back-pressure, so the back end never stalls.
// Reset is asynchronous, active low; counts come up as 32 x 16 (capped at the
// maximum division count). No clearing pass.

module uv_sphere_cell_tessellator_top #(
	parameter int MAX_DIVISIONS = uvs_pkg::MAX_DIVISIONS_DEF,
	parameter int FRAC_BITS     = uvs_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [uvs_pkg::IDX_W-1:0]          column,
	input  logic [uvs_pkg::IDX_W-1:0]          row,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [uvs_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [uvs_pkg::CNT_W-1:0]          cfg_data,
	output logic                               vertex_valid,
	output logic signed [uvs_pkg::OUT_W-1:0]   pos_x,
	output logic signed [uvs_pkg::OUT_W-1:0]   pos_y,
	output logic signed [uvs_pkg::OUT_W-1:0]   pos_z,
	output logic [uvs_pkg::OUT_W-1:0]          tex_s,
	output logic [uvs_pkg::OUT_W-1:0]          tex_t,
	output logic [uvs_pkg::SLOT_W-1:0]         vertex_slot,
	output logic                               last,
	output logic                               cell_error
);
	import uvs_pkg::*;

	grid_cfg_t     grid;
	queue_status_t q_status;
	cell_req_t     req, head;
	logic          push, pop;

	// front: register file, grid check, request push
	uvs_front #(
		.MAX_DIVISIONS(MAX_DIVISIONS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.column    (column),
		.row       (row),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.grid      (grid),
		.q_status  (q_status),
		.push      (push),
		.req       (req)
	);

	// decouples request intake from vertex generation
	uvs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (req),
		.pop    (pop),
		.rdata  (head),
		.status (q_status)
	);

	// back: six-slot sequencer, dividers, rotation units, rounding
	uvs_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.grid         (grid),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.vertex_valid (vertex_valid),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.tex_s        (tex_s),
		.tex_t        (tex_t),
		.vertex_slot  (vertex_slot),
		.last         (last),
		.cell_error   (cell_error)
	);

endmodule

`default_nettype wire
